/* design/dlle_pkg.sv */
// Package for the doubly linked list engine: sizes, operation and status codes,
// and the controller/datapath command and status structs. No dependencies.
`default_nettype none
package dlle_pkg;
   localparam int POOL_NODES = 64;
   localparam int ITEM_BITS  = 32;
   localparam int IDX_BITS   = $clog2(POOL_NODES);
   localparam int CNT_BITS   = $clog2(POOL_NODES + 1);
   localparam int CAP_BITS   = 7;

   // operation codes
   localparam logic [2:0] FUNC_APPEND = 3'd0;
   localparam logic [2:0] FUNC_POP    = 3'd1;
   localparam logic [2:0] FUNC_REMOVE = 3'd2;
   localparam logic [2:0] FUNC_INS_BF = 3'd3;
   localparam logic [2:0] FUNC_INS_AF = 3'd4;
   localparam logic [2:0] FUNC_READ   = 3'd5;
   localparam logic [2:0] FUNC_NEXT   = 3'd6;
   localparam logic [2:0] FUNC_PREV   = 3'd7;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_BAD   = 2'd3;

   // link word: null flag over index
   typedef struct packed {
      logic                nul;
      logic [IDX_BITS-1:0] idx;
   } link_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch request beat, start link reads
      logic decide;    // evaluate operation with link read data
      logic patch;     // neighbor link writes
      logic finish;    // load response register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic rsp_busy;  // response register holds an untaken beat
   } dp_sts_type;
endpackage
`default_nettype wire

/* design/dlle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dlle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* design/dlle_datapath.sv */
// Datapath: link and item memories, head/tail/count, in-use bits, free search,
// response register. Uses dlle_pkg and dlle_ram.
`default_nettype none
module dlle_datapath
   import dlle_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dp_cmd_type           cmd,
   output dp_sts_type                sts,
   input  wire logic [2:0]           req_func,
   input  wire logic [IDX_BITS-1:0]  req_node_handle,
   input  wire logic [ITEM_BITS-1:0] req_item_value,
   input  wire logic                 csr_wr_en,
   input  wire logic [CAP_BITS-1:0]  csr_wr_data,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic [IDX_BITS-1:0]       rsp_result_handle,
   output logic                      rsp_result_handle_null,
   output logic [ITEM_BITS-1:0]      rsp_result_item,
   output logic [IDX_BITS-1:0]       rsp_first_handle,
   output logic [IDX_BITS-1:0]       rsp_last_handle,
   output logic [CNT_BITS-1:0]       rsp_entry_count,
   output logic                      rsp_list_empty,
   output logic                      rsp_list_full
);
   localparam link_type NIL = '{nul: 1'b1, idx: '0};

   // architectural state
   logic [CAP_BITS-1:0]   cap_ff;
   logic [POOL_NODES-1:0] used_ff, used_in;
   link_type              head_ff, head_in, tail_ff, tail_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   // request latch
   logic [2:0]           func_ff;
   logic [IDX_BITS-1:0]  hnd_ff;
   logic [ITEM_BITS-1:0] val_ff;

   // decided operation
   logic [1:0]           st_ff, st_in;
   link_type             rh_ff, rh_in;
   logic                 isitem_in;
   logic                 wr_p_ff, wr_p_in, wr_q_ff, wr_q_in;
   link_type             p_ff, p_in, q_ff, q_in;
   link_type             pv_ff, pv_in, qv_ff, qv_in;  // value for next[p], prev[q]

   // free slot: lowest clear bit, priority encoder
   logic [IDX_BITS-1:0] free_idx;
   logic                free_ok;
   always_comb begin
      free_idx = '0;
      free_ok  = 1'b0;
      for (int i = POOL_NODES - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = IDX_BITS'(i);
            free_ok  = 1'b1;
         end
      end
   end

   // memories, read address: handle (or head for pop)
   logic [IDX_BITS-1:0]  rd_addr;
   link_type             nx_rd, pr_rd;
   logic [ITEM_BITS-1:0] it_rd;
   logic                 nx_we, pr_we, it_we;
   logic [IDX_BITS-1:0]  nx_wa, pr_wa;
   link_type             nx_wd, pr_wd;

   assign rd_addr = (req_func == FUNC_POP) ? head_ff.idx : req_node_handle;

   dlle_ram #(.WIDTH(IDX_BITS + 1), .DEPTH(POOL_NODES)) u_next (
      .clock, .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_addr, .rd_data(nx_rd));
   dlle_ram #(.WIDTH(IDX_BITS + 1), .DEPTH(POOL_NODES)) u_prev (
      .clock, .wr_en(pr_we), .wr_addr(pr_wa), .wr_data(pr_wd),
      .rd_addr, .rd_data(pr_rd));
   dlle_ram #(.WIDTH(ITEM_BITS), .DEPTH(POOL_NODES)) u_item (
      .clock, .wr_en(it_we), .wr_addr(rh_ff.idx), .wr_data(val_ff),
      .rd_addr, .rd_data(it_rd));

   // decide: full check, new links, state updates
   logic [CNT_BITS:0] lim;
   logic              valid_h, full_now, is_ins, is_del;
   link_type          hl;
   always_comb begin
      lim      = (cap_ff > CAP_BITS'(POOL_NODES)) ? (CNT_BITS+1)'(POOL_NODES)
                                                  : (CNT_BITS+1)'(cap_ff);
      valid_h  = used_ff[hnd_ff];
      full_now = {1'b0, count_ff} >= lim;
      hl       = '{nul: 1'b0, idx: hnd_ff};
      st_in = ST_OK; rh_in = NIL; isitem_in = 1'b0;
      wr_p_in = 1'b0; wr_q_in = 1'b0;
      p_in = NIL; q_in = NIL; pv_in = NIL; qv_in = NIL;
      is_ins = 1'b0; is_del = 1'b0;
      unique case (func_ff) inside
         FUNC_APPEND: begin
            if (full_now || !free_ok) st_in = ST_FULL;
            else begin is_ins = 1'b1; p_in = tail_ff; q_in = NIL; end
         end
         FUNC_POP: begin
            if (count_ff == '0 || head_ff.nul) st_in = ST_EMPTY;
            else begin
               is_del = 1'b1; isitem_in = 1'b1;
               rh_in = head_ff; p_in = pr_rd; q_in = nx_rd;
            end
         end
         FUNC_REMOVE: begin
            if (!valid_h) st_in = ST_BAD;
            else begin is_del = 1'b1; rh_in = hl; p_in = pr_rd; q_in = nx_rd; end
         end
         FUNC_INS_BF, FUNC_INS_AF: begin
            if (!valid_h) st_in = ST_BAD;
            else if (full_now || !free_ok) st_in = ST_FULL;
            else begin
               is_ins = 1'b1;
               p_in = (func_ff == FUNC_INS_BF) ? pr_rd : hl;
               q_in = (func_ff == FUNC_INS_BF) ? hl : nx_rd;
            end
         end
         FUNC_READ: begin
            if (!valid_h) st_in = ST_BAD;
            else begin rh_in = hl; isitem_in = 1'b1; end
         end
         default: begin
            if (!valid_h) st_in = ST_BAD;
            else rh_in = (func_ff == FUNC_NEXT) ? nx_rd : pr_rd;
         end
      endcase
      used_in = used_ff; head_in = head_ff; tail_in = tail_ff; count_in = count_ff;
      if (is_ins) begin
         rh_in = '{nul: 1'b0, idx: free_idx};
         used_in[free_idx] = 1'b1;
         pv_in = rh_in; qv_in = rh_in;
         if (p_in.nul) head_in = rh_in; else wr_p_in = 1'b1;
         if (q_in.nul) tail_in = rh_in; else wr_q_in = 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (is_del) begin
         used_in[rh_in.idx] = 1'b0;
         pv_in = q_in; qv_in = p_in;
         if (p_in.nul) head_in = q_in; else wr_p_in = 1'b1;
         if (q_in.nul) tail_in = p_in; else wr_q_in = 1'b1;
         if (count_ff != '0) count_in = count_ff - 1'b1;
      end
   end

   // memory writes: patch cycle writes the new item and fixes neighbors, finish cycle writes the new node's own links
   logic new_node_ff;
   always_comb begin
      it_we = cmd.patch && new_node_ff;
      nx_we = cmd.patch ? (wr_p_ff || new_node_ff) : 1'b0;
      nx_wa = p_ff.idx; nx_wd = pv_ff;
      pr_we = 1'b0; pr_wa = q_ff.idx; pr_wd = qv_ff;
      if (cmd.finish) begin
         // second write slot: new node's own links
         nx_we = new_node_ff; nx_wa = rh_ff.idx; nx_wd = q_ff;
         pr_we = new_node_ff; pr_wa = rh_ff.idx; pr_wd = p_ff;
      end else if (cmd.patch) begin
         nx_we = wr_p_ff; pr_we = wr_q_ff;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_BITS'(POOL_NODES);
         used_ff <= '0; head_ff <= NIL; tail_ff <= NIL; count_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_wr_en) cap_ff <= csr_wr_data;
         if (cmd.decide) begin
            used_ff <= used_in; head_ff <= head_in;
            tail_ff <= tail_in; count_ff <= count_in;
         end
         if (cmd.finish) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
      end
   end

   // payload registers
   logic [ITEM_BITS-1:0] item_hold_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func; hnd_ff <= req_node_handle; val_ff <= req_item_value;
      end
      if (cmd.decide) begin
         st_ff <= st_in; rh_ff <= rh_in;
         wr_p_ff <= wr_p_in; wr_q_ff <= wr_q_in;
         p_ff <= p_in; q_ff <= q_in; pv_ff <= pv_in; qv_ff <= qv_in;
         new_node_ff <= is_ins;
         item_hold_ff <= isitem_in ? it_rd : '0;
      end
      if (cmd.finish) begin
         rsp_status <= st_ff;
         rsp_result_handle <= rh_ff.nul ? '0 : rh_ff.idx;
         rsp_result_handle_null <= rh_ff.nul;
         rsp_result_item <= item_hold_ff;
         rsp_first_handle <= head_ff.nul ? '0 : head_ff.idx;
         rsp_last_handle <= tail_ff.nul ? '0 : tail_ff.idx;
         rsp_entry_count <= count_ff;
         rsp_list_empty <= (count_ff == '0);
         rsp_list_full <= {1'b0, count_ff} >= lim;
      end
   end

   assign sts.rsp_busy = rsp_valid && rsp_stall;

   // head and tail are null together
   a_ends: assert property (@(posedge clock) disable iff (reset)
      head_ff.nul == tail_ff.nul) else $error("head/tail null mismatch");
   // count matches in-use bits
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(count_ff)) else $error("count drift");
   // empty list has a null head
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> head_ff.nul) else $error("empty list has head");
endmodule
`default_nettype wire

/* design/dlle_ctrl.sv */
// Controller: sequences capture, decide, patch and finish for one beat.
// Uses dlle_pkg.
`default_nettype none
module dlle_ctrl
   import dlle_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output dp_cmd_type      cmd,
   input  wire dp_sts_type sts
);
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_PATCH  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_DECIDE;
         S_DECIDE: state_in = S_PATCH;
         S_PATCH:  state_in = S_FINISH;
         S_FINISH: if (!sts.rsp_busy) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign cmd.capture = (state_ff == S_IDLE) && req_valid;
   assign cmd.decide  = (state_ff == S_DECIDE);
   assign cmd.patch   = (state_ff == S_PATCH);
   assign cmd.finish  = (state_ff == S_FINISH) && !sts.rsp_busy;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   a_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> cmd.patch) else $error("patch must follow decide");
   a_one: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.decide, cmd.patch, cmd.finish}))
      else $error("overlapping commands");
   a_fin: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !req_stall) else $error("finish must free input");
endmodule
`default_nettype wire

/* design/doubly_linked_list_engine_top.sv */
// Top level of the doubly linked list engine: controller plus datapath.
// Uses dlle_pkg, dlle_ctrl, dlle_datapath.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | func, node_handle, item_value
//  rsp     | out       | rsp_valid/rsp_stall  | status, handles, item, count, flags
//  csr     | in        | csr_wr_en            | capacity_limit
//
// One beat runs through capture, decide (link read data), patch and finish;
// the split is set by the single write port of each link memory.
// Response register lets the next request start while a result waits.
// Synchronous reset clears head, tail, count and in-use bits; memories keep data.
`default_nettype none
module doubly_linked_list_engine_top
   import dlle_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [2:0]           req_func,
   input  wire logic [IDX_BITS-1:0]  req_node_handle,
   input  wire logic [ITEM_BITS-1:0] req_item_value,
   input  wire logic                 csr_wr_en,
   input  wire logic [CAP_BITS-1:0]  csr_wr_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [IDX_BITS-1:0]       rsp_result_handle,
   output logic                      rsp_result_handle_null,
   output logic [ITEM_BITS-1:0]      rsp_result_item,
   output logic [IDX_BITS-1:0]       rsp_first_handle,
   output logic [IDX_BITS-1:0]       rsp_last_handle,
   output logic [CNT_BITS-1:0]       rsp_entry_count,
   output logic                      rsp_list_empty,
   output logic                      rsp_list_full
);
   dp_cmd_type cmd;
   dp_sts_type sts;

   dlle_ctrl u_ctrl (.clock, .reset, .req_valid, .req_stall, .cmd, .sts);

   dlle_datapath u_dp (
      .clock, .reset, .cmd, .sts, .req_func, .req_node_handle, .req_item_value,
      .csr_wr_en, .csr_wr_data, .rsp_stall, .rsp_valid, .rsp_status,
      .rsp_result_handle, .rsp_result_handle_null, .rsp_result_item,
      .rsp_first_handle, .rsp_last_handle, .rsp_entry_count, .rsp_list_empty,
      .rsp_list_full);
endmodule
`default_nettype wire
